// ----- design/lpf_pkg.sv -----
`timescale 1ns / 1ps
// lpf_pkg: shared types and constants for the length prefixed packet framer
// no dependencies

package lpf_pkg;

  localparam int HEADER_BYTES   = 2;
  localparam int MaxHeaderBits  = 64;
  localparam int CfgIndexWidth  = 3;
  localparam int LengthWidth    = 9;
  localparam int PositionWidth  = 16;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_LENGTH_BYTE_OFFSET = 3'd0,
    CFG_HEADER_OFFSET      = 3'd1,
    CFG_PATTERN_A          = 3'd2,
    CFG_PATTERN_B          = 3'd3,
    CFG_PATTERN_C          = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_AB      = 2'd1,
    KIND_C       = 2'd2
  } kind_t;

  typedef struct packed {
    logic [2:0]  length_byte_offset;
    logic [2:0]  header_offset;
    logic [15:0] pattern_a;
    logic [15:0] pattern_b;
    logic [15:0] pattern_c;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       segment_end;
  } in_t;

  typedef struct packed {
    logic [1:0]               packet_kind;
    logic [LengthWidth-1:0]   packet_length;
    logic [PositionWidth-1:0] start_position;
  } out_t;

endpackage

// ----- design/length_prefixed_packet_framer.sv -----
`timescale 1ns / 1ps
// length_prefixed_packet_framer: top level of the packet framer
// depends on lpf_pkg, lpf_cfg_regs, lpf_core, lpf_out_reg

// Cuts a byte stream segment into back-to-back length-prefixed packets and
// reports kind, length and start offset of each completed packet. One byte is
// taken per clock unless in_stall holds it, as when out_stall back-pressures;
// the byte that completes a packet passes from the input register through the
// packet state logic into the result register, which drives out_data. An
// incomplete packet at segment end is dropped. Configuration registers take
// effect at once and should be written only while no request is in flight.

module length_prefixed_packet_framer #(
  parameter int HEADER_BYTES = lpf_pkg::HEADER_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lpf_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lpf_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpf_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [15:0]                       cfg_data
);

  lpf_pkg::cfg_t cfg;
  logic          res_valid;
  lpf_pkg::out_t res_data;
  logic          res_ready;

  lpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpf_core #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  lpf_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/lpf_cfg_regs.sv -----
`timescale 1ns / 1ps
// lpf_cfg_regs: configuration register file of the framer
// depends on lpf_pkg

module lpf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lpf_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [15:0]                        cfg_data,
  output lpf_pkg::cfg_t                      cfg
);

  lpf_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.length_byte_offset <= 3'd0;
      cfg_r.header_offset      <= 3'd1;
      cfg_r.pattern_a          <= 16'd0;
      cfg_r.pattern_b          <= 16'd0;
      cfg_r.pattern_c          <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lpf_pkg::CFG_LENGTH_BYTE_OFFSET: cfg_r.length_byte_offset <= cfg_data[2:0];
        lpf_pkg::CFG_HEADER_OFFSET:      cfg_r.header_offset      <= cfg_data[2:0];
        lpf_pkg::CFG_PATTERN_A:          cfg_r.pattern_a          <= cfg_data;
        lpf_pkg::CFG_PATTERN_B:          cfg_r.pattern_b          <= cfg_data;
        lpf_pkg::CFG_PATTERN_C:          cfg_r.pattern_c          <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/lpf_core.sv -----
`timescale 1ns / 1ps
// lpf_core: input register, packet state and per-byte framing logic
// depends on lpf_pkg

module lpf_core #(
  parameter int HEADER_BYTES = lpf_pkg::HEADER_BYTES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lpf_pkg::in_t  in_data,
  input  lpf_pkg::cfg_t cfg,
  output logic          res_valid,
  output lpf_pkg::out_t res_data,
  input  logic          res_ready
);

  localparam int HeaderBits = 8 * HEADER_BYTES;
  localparam int CountWidth = $clog2(HEADER_BYTES + 1);
  localparam int LaneWidth  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int LenW       = lpf_pkg::LengthWidth;
  localparam int PosW       = lpf_pkg::PositionWidth;

  logic                  in_vld_r;
  lpf_pkg::in_t          in_r;
  logic [PosW-1:0]       seg_pos_r,   seg_pos_nxt;
  logic [PosW-1:0]       pkt_start_r, pkt_start_nxt;
  logic [LenW-1:0]       pkt_bytes_r, pkt_bytes_nxt;
  logic [LenW-1:0]       cur_len_r,   cur_len_nxt;
  logic                  len_known_r, len_known_nxt;
  logic [HeaderBits-1:0] hdr_r,       hdr_nxt;
  logic [CountWidth-1:0] hdr_cnt_r,   hdr_cnt_nxt;

  logic                  advance;
  logic                  done;
  logic [PosW-1:0]       start_now;
  logic [LenW-1:0]       hdr_lo;
  logic [LenW-1:0]       hdr_hi;
  logic                  in_hdr;
  logic [LaneWidth-1:0]  lane;
  logic [HeaderBits-1:0] hdr_now;
  logic [CountWidth-1:0] cnt_now;
  logic                  len_hit;
  logic [LenW-1:0]       len_now;
  logic                  known_now;
  logic [LenW-1:0]       bytes_now;
  logic                  hdr_full;
  logic [lpf_pkg::MaxHeaderBits-1:0] pat_a_ext, pat_b_ext, pat_c_ext;
  logic [1:0]            kind;

  assign advance   = in_vld_r && (!done || res_ready);
  assign in_stall  = in_vld_r && !advance;
  assign res_valid = in_vld_r && done;

  assign pat_a_ext = {{(lpf_pkg::MaxHeaderBits - 16){1'b0}}, cfg.pattern_a};
  assign pat_b_ext = {{(lpf_pkg::MaxHeaderBits - 16){1'b0}}, cfg.pattern_b};
  assign pat_c_ext = {{(lpf_pkg::MaxHeaderBits - 16){1'b0}}, cfg.pattern_c};

  // per-byte step
  always_comb begin
    start_now = (pkt_bytes_r == '0) ? seg_pos_r : pkt_start_r;

    hdr_lo = {{(LenW - 3){1'b0}}, cfg.header_offset};
    hdr_hi = hdr_lo + LenW'(HEADER_BYTES);
    in_hdr = (pkt_bytes_r >= hdr_lo) && (pkt_bytes_r < hdr_hi);
    lane   = LaneWidth'(pkt_bytes_r - hdr_lo);

    hdr_now = hdr_r;
    for (int j = 0; j < HEADER_BYTES; j++) begin
      if (in_hdr && lane == LaneWidth'(j)) begin
        hdr_now[8*j +: 8] = hdr_r[8*j +: 8] | in_r.data_byte;
      end
    end

    cnt_now = hdr_cnt_r;
    if (in_hdr && hdr_cnt_r < CountWidth'(HEADER_BYTES)) begin
      cnt_now = hdr_cnt_r + CountWidth'(1);
    end

    len_hit   = !len_known_r && (pkt_bytes_r == {{(LenW - 3){1'b0}}, cfg.length_byte_offset});
    len_now   = len_hit ? ({1'b0, in_r.data_byte} + LenW'(1)) : cur_len_r;
    known_now = len_known_r || len_hit;

    // saturating so a packet whose length byte was skipped never wraps
    bytes_now = (pkt_bytes_r == {LenW{1'b1}}) ? pkt_bytes_r : pkt_bytes_r + LenW'(1);
    done      = known_now && (bytes_now >= len_now);

    hdr_full = (cnt_now == CountWidth'(HEADER_BYTES));
    if (!hdr_full) begin
      kind = lpf_pkg::KIND_UNKNOWN;
    end else if (hdr_now == pat_a_ext[HeaderBits-1:0] ||
                 hdr_now == pat_b_ext[HeaderBits-1:0]) begin
      kind = lpf_pkg::KIND_AB;
    end else if (hdr_now == pat_c_ext[HeaderBits-1:0]) begin
      kind = lpf_pkg::KIND_C;
    end else begin
      kind = lpf_pkg::KIND_UNKNOWN;
    end

    res_data.packet_kind    = kind;
    res_data.packet_length  = bytes_now;
    res_data.start_position = start_now;

    seg_pos_nxt   = (seg_pos_r == {PosW{1'b1}}) ? seg_pos_r : seg_pos_r + PosW'(1);
    pkt_start_nxt = start_now;
    pkt_bytes_nxt = bytes_now;
    cur_len_nxt   = len_now;
    len_known_nxt = known_now;
    hdr_nxt       = hdr_now;
    hdr_cnt_nxt   = cnt_now;

    if (done || in_r.segment_end) begin
      pkt_start_nxt = '0;
      pkt_bytes_nxt = '0;
      cur_len_nxt   = '0;
      len_known_nxt = 1'b0;
      hdr_nxt       = '0;
      hdr_cnt_nxt   = '0;
    end
    if (in_r.segment_end) begin
      seg_pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_vld_r || advance) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_pos_r   <= '0;
      pkt_start_r <= '0;
      pkt_bytes_r <= '0;
      cur_len_r   <= '0;
      len_known_r <= 1'b0;
      hdr_r       <= '0;
      hdr_cnt_r   <= '0;
    end else if (advance) begin
      seg_pos_r   <= seg_pos_nxt;
      pkt_start_r <= pkt_start_nxt;
      pkt_bytes_r <= pkt_bytes_nxt;
      cur_len_r   <= cur_len_nxt;
      len_known_r <= len_known_nxt;
      hdr_r       <= hdr_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
    end
  end

endmodule

// ----- design/lpf_out_reg.sv -----
`timescale 1ns / 1ps
// lpf_out_reg: result register between the framing logic and the output channel
// depends on lpf_pkg

module lpf_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  lpf_pkg::out_t res_data,
  output logic          res_ready,
  output logic          out_valid,
  input  logic          out_stall,
  output lpf_pkg::out_t out_data
);

  logic          out_valid_r;
  lpf_pkg::out_t out_data_r;

  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

endmodule
